// ----- hw/rtl/sbi_pkg.sv -----
// shared types and constants for the segment versus box slab test
// no dependencies
package sbi_pkg;

	localparam int unsigned CoordW = 24;
	localparam int unsigned AxisN  = 3;
	localparam int unsigned DiffW  = 26;
	localparam int unsigned MagW   = 25;
	localparam int unsigned FracW  = 17;
	localparam int unsigned DivN   = 17;
	localparam logic [FracW-1:0] FracOne = 17'h10000;

	// per-axis control carried beside the dividers
	typedef struct packed {
		logic use_st;
		logic use_et;
	} axis_ctl_t;

	typedef struct packed {
		logic                    reject;
		axis_ctl_t [AxisN-1:0]   axis;
	} item_ctl_t;

endpackage

// ----- hw/rtl/sbi_div.sv -----
// pipelined restoring divider, one quotient bit per stage, quotient up to 1.0 in Q1.16
// depends on sbi_pkg
module sbi_div
	import sbi_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [MagW-1:0]  num,
	input  logic [MagW-1:0]  den,
	output logic [FracW-1:0] quo
);

	logic [MagW:0]    rem_s [0:DivN-2];
	logic [MagW-1:0]  den_s [0:DivN-2];
	logic [FracW-1:0] quo_s [0:DivN-1];

	// one compare and subtract per stage
	for (genvar i = 0; i < DivN; i++) begin : g_step
		logic [MagW:0]    r_in;
		logic [MagW-1:0]  d_in;
		logic [FracW-1:0] q_in;
		logic [MagW:0]    r_sub;
		logic             ge;

		if (i == 0) begin : g_first
			assign r_in = {1'b0, num};
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = {rem_s[i-1][MagW-1:0], 1'b0};
			assign d_in = den_s[i-1];
			assign q_in = quo_s[i-1];
		end

		assign ge    = r_in >= {1'b0, d_in};
		assign r_sub = r_in - {1'b0, d_in};

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[i] <= {q_in[FracW-2:0], ge};
			end
		end

		if (i < DivN - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= ge ? r_sub : r_in;
					den_s[i] <= d_in;
				end
			end
		end
	end

	assign quo = quo_s[DivN-1];

endmodule

// ----- hw/rtl/segment_box_intersect.sv -----
// segment versus axis-aligned box slab test, top level
// depends on sbi_pkg and sbi_div
//
// Input channel s_*: one item per handshake holding the segment start and
// end points and the box min and max corners, signed Q15.8, 24 bits each.
// Output channel m_*: one item per input item, hit flag on m_tuser and the
// entry fraction (Q1.16, 65536 = 1.0, zero on a miss) on m_tdata.
// One stage forms differences and slab tests, six pipelined dividers
// produce one quotient bit per stage over 17 stages, and one stage
// merges the axes into the output register. Throughput is one item
// per cycle unless the output stalls; items leave in arrival order.
// When the receiver holds m_tready low with an item waiting, the whole
// pipeline freezes and s_tready falls; nothing is dropped or repeated.
// Reset clears every valid bit, so the pipeline starts empty and the
// block accepts an item in the first cycle after reset is released.
module segment_box_intersect
	import sbi_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// start_x, start_y, start_z, end_x, end_y, end_z,
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
	input  logic [287:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// entry_time, zero padded
	output logic [23:0]  m_tdata,
	// hit
	output logic         m_tuser
);

	logic      en;
	logic      vld_s1;
	item_ctl_t ctl_in;
	item_ctl_t ctl_s1;
	logic      [MagW-1:0] nst_in [0:AxisN-1];
	logic      [MagW-1:0] net_in [0:AxisN-1];
	logic      [MagW-1:0] den_in [0:AxisN-1];
	logic      [MagW-1:0] nst_s1 [0:AxisN-1];
	logic      [MagW-1:0] net_s1 [0:AxisN-1];
	logic      [MagW-1:0] den_s1 [0:AxisN-1];
	logic      [FracW-1:0] qst [0:AxisN-1];
	logic      [FracW-1:0] qet [0:AxisN-1];
	logic      vld_d_s [0:DivN-1];
	item_ctl_t ctl_d_s [0:DivN-1];
	logic      [AxisN-1:0] rej_ax;
	logic      [FracW-1:0] fst;
	logic      [FracW-1:0] fet;
	logic      [FracW-1:0] st_ax [0:AxisN-1];
	logic      [FracW-1:0] et_ax [0:AxisN-1];
	logic      hit;

	// whole pipeline advances unless a finished item is stuck at the output
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// slab tests and signed differences per axis
	for (genvar a = 0; a < AxisN; a++) begin : g_axis
		logic signed [CoordW-1:0] s, e, lo, hi;
		logic signed [DiffW-1:0]  dn, nlo, nhi, ast, aet;
		logic                     rising;

		assign s  = s_tdata[CoordW*a +: CoordW];
		assign e  = s_tdata[CoordW*(AxisN+a) +: CoordW];
		assign lo = s_tdata[CoordW*(2*AxisN+a) +: CoordW];
		assign hi = s_tdata[CoordW*(3*AxisN+a) +: CoordW];

		assign rising = s < e;
		assign dn  = DiffW'(e) - DiffW'(s);
		assign nlo = DiffW'(lo) - DiffW'(s);
		assign nhi = DiffW'(hi) - DiffW'(s);

		assign rej_ax[a] = rising ? (s > hi || e < lo) : (e > hi || s < lo);
		assign ctl_in.axis[a].use_st = rising ? (s < lo) : (s > hi);
		assign ctl_in.axis[a].use_et = rising ? (e > hi) : (e < lo);

		// numerator and divisor share a sign, so divide magnitudes
		assign ast = rising ? nlo : -nhi;
		assign aet = rising ? nhi : -nlo;
		assign nst_in[a] = ast[MagW-1:0];
		assign net_in[a] = aet[MagW-1:0];
		assign den_in[a] = rising ? dn[MagW-1:0] : MagW'(-dn);

		always_ff @(posedge clk) begin
			if (en) begin
				nst_s1[a] <= nst_in[a];
				net_s1[a] <= net_in[a];
				den_s1[a] <= den_in[a];
			end
		end

		sbi_div u_div_st (
			.clk (clk),
			.en  (en),
			.num (nst_s1[a]),
			.den (den_s1[a]),
			.quo (qst[a])
		);

		sbi_div u_div_et (
			.clk (clk),
			.en  (en),
			.num (net_s1[a]),
			.den (den_s1[a]),
			.quo (qet[a])
		);
	end

	assign ctl_in.reject = |rej_ax;

	// front stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	// control rides beside the divider stages
	for (genvar i = 0; i < DivN; i++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_d_s[i] <= 1'b0;
			end else if (en) begin
				vld_d_s[i] <= (i == 0) ? vld_s1 : vld_d_s[(i == 0) ? 0 : i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_d_s[i] <= (i == 0) ? ctl_s1 : ctl_d_s[(i == 0) ? 0 : i-1];
			end
		end
	end

	// merge axes: latest entry, earliest exit
	always_comb begin
		for (int a = 0; a < AxisN; a++) begin
			st_ax[a] = ctl_d_s[DivN-1].axis[a].use_st ? qst[a] : '0;
			et_ax[a] = ctl_d_s[DivN-1].axis[a].use_et ? qet[a] : FracOne;
		end
		fst = '0;
		fet = FracOne;
		for (int a = 0; a < AxisN; a++) begin
			if (st_ax[a] > fst) fst = st_ax[a];
			if (et_ax[a] < fet) fet = et_ax[a];
		end
		hit = !ctl_d_s[DivN-1].reject && (fet >= fst);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_d_s[DivN-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tuser <= hit;
			m_tdata <= {7'b0, hit ? fst : {FracW{1'b0}}};
		end
	end

`ifndef SYNTHESIS
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 24'd0)
		else $error("miss with nonzero entry time");

	a_entry_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:FracW] == '0 && m_tdata[FracW-1:0] <= FracOne)
		else $error("entry time out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed under stall");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not track output space");
`endif

endmodule

// ----- test/tb_segment_box_intersect.sv -----
// testbench for segment_box_intersect: directed table then random segment/box items
// depends on sbi_pkg and the segment_box_intersect rtl; predicts hit and entry fraction
module tb_segment_box_intersect
	import sbi_pkg::*;
();

	typedef logic signed [CoordW-1:0] coord_t;

	typedef struct packed {
		logic             hit;
		logic [FracW-1:0] entry;
	} isect_t;

	typedef struct {
		coord_t c [12];
		logic   known;
		isect_t res;
	} vec_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [287:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [23:0]  m_tdata;
	logic         m_tuser;

	isect_t expected_q[$];
	int     mismatches;
	int     send_idle_pct;
	int     recv_stall_pct;
	int     hold_off;
	int     hold_req;
	int     hold_seen;

	segment_box_intersect uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// truncated quotient of same-signed values, saturated to one
	function automatic logic [FracW-1:0] slab_frac(longint num, longint den);
		longint un, ud, q;
		un = num < 0 ? -num : num;
		ud = den < 0 ? -den : den;
		if (ud == 0)
			return FracOne;
		q = (un << 16) / ud;
		if (q > 65536)
			q = 65536;
		return q[FracW-1:0];
	endfunction

	// slab test over x, y, z
	function automatic isect_t slab_test(coord_t c [12]);
		isect_t r;
		longint s, e, lo, hi, d;
		logic [FracW-1:0] fst, fet, st, et;
		fst = '0;
		fet = FracOne;
		r.hit = 1'b1;
		for (int ax = 0; ax < 3; ax++) begin
			s = c[ax]; e = c[3+ax]; lo = c[6+ax]; hi = c[9+ax];
			d = e - s;
			if (s < e) begin
				if (s > hi || e < lo) begin
					r.hit = 1'b0;
					break;
				end
				st = (s < lo) ? slab_frac(lo - s, d) : '0;
				et = (e > hi) ? slab_frac(hi - s, d) : FracOne;
			end else begin
				if (e > hi || s < lo) begin
					r.hit = 1'b0;
					break;
				end
				st = (s > hi) ? slab_frac(hi - s, d) : '0;
				et = (e < lo) ? slab_frac(lo - s, d) : FracOne;
			end
			if (st > fst) fst = st;
			if (et < fet) fet = et;
			if (fet < fst) begin
				r.hit = 1'b0;
				break;
			end
		end
		r.entry = r.hit ? fst : '0;
		return r;
	endfunction

	function automatic coord_t rnd_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 4095)) - 24'sd2048;
			default: return coord_t'($urandom_range(0, 255)) - 24'sd128;
		endcase
	endfunction

	// random item, mostly boxes the segment can plausibly meet
	function automatic vec_t rnd_item();
		vec_t v;
		coord_t a, b;
		int mode;
		mode = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
		for (int i = 0; i < 6; i++)
			v.c[i] = rnd_coord(mode);
		for (int ax = 0; ax < 3; ax++) begin
			a = rnd_coord(mode);
			b = rnd_coord(mode);
			// occasionally leave the box inverted
			if ((a > b) && $urandom_range(0, 9) != 0) begin
				v.c[6+ax] = b; v.c[9+ax] = a;
			end else begin
				v.c[6+ax] = a; v.c[9+ax] = b;
			end
		end
		v.known = 1'b0;
		return v;
	endfunction

	function automatic vec_t mk(int sx, int sy, int sz, int ex, int ey, int ez,
			int nx, int ny, int nz, int xx, int xy, int xz, bit known, bit h, int t);
		vec_t v;
		int vals [12];
		vals = '{sx, sy, sz, ex, ey, ez, nx, ny, nz, xx, xy, xz};
		for (int i = 0; i < 12; i++)
			v.c[i] = coord_t'(vals[i]);
		v.known = known;
		v.res.hit = h;
		v.res.entry = FracW'(t);
		return v;
	endfunction

	// valid stays high across back to back items, drops only while idling
	task automatic send_item(vec_t v);
		logic [287:0] d;
		isect_t pred;
		for (int i = 0; i < 12; i++)
			d[i*24 +: 24] = v.c[i];
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pred = slab_test(v.c);
		if (v.known && pred != v.res) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row disagrees with prediction: exp %0d/%0d pred %0d/%0d",
					v.res.hit, v.res.entry, pred.hit, pred.entry);
		end
		expected_q.insert(expected_q.size(), v.known ? v.res : pred);
	endtask

	// receiver: random stalls plus a requested long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_off  <= 0;
			hold_seen <= 0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_off  <= 200;
			m_tready  <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		isect_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: hit %0d entry %0d", m_tuser, m_tdata);
			end else begin
				want = expected_q.pop_front();
				if (m_tuser !== want.hit || m_tdata !== {7'd0, want.entry}) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp hit %0d entry %0d, got hit %0d entry %0d",
							want.hit, want.entry, m_tuser, m_tdata);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("tb_segment_box_intersect: done, errors");
		$finish;
	end

	initial begin
		vec_t table_rows[$];
		int waited;
		s_tvalid = 1'b0;
		s_tdata = '0;
		hold_req = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows: full miss, full hit, touching, extremes, flat and inverted
		table_rows.insert(table_rows.size(),
			mk(0,0,0, 256,256,256, 0,0,0, 256,256,256, 1, 1, 0));
		table_rows.insert(table_rows.size(),
			mk(-512,0,0, 512,0,0, 0,-256,-256, 256,256,256, 1, 1, 32768));
		table_rows.insert(table_rows.size(),
			mk(1024,0,0, 2048,0,0, 0,0,0, 256,256,256, 1, 0, 0));
		table_rows.insert(table_rows.size(),
			mk(2048,0,0, 1024,0,0, 0,0,0, 256,256,256, 1, 0, 0));
		table_rows.insert(table_rows.size(),
			mk(0,0,0, 256,0,0, 256,0,0, 512,0,0, 1, 1, 65536));
		table_rows.insert(table_rows.size(),
			mk(0,0,0, 0,0,0, 0,0,0, 0,0,0, 1, 1, 0));
		table_rows.insert(table_rows.size(),
			mk(0,0,0, 0,0,0, 256,0,0, 0,0,0, 1, 0, 0));
		table_rows.insert(table_rows.size(),
			mk(-8388608,-8388608,-8388608, 8388607,8388607,8388607,
			-8388608,-8388608,-8388608, 8388607,8388607,8388607, 1, 1, 0));
		table_rows.insert(table_rows.size(),
			mk(8388607,8388607,8388607, -8388608,-8388608,-8388608,
			-8388608,-8388608,-8388608, 8388607,8388607,8388607, 1, 1, 0));
		table_rows.insert(table_rows.size(),
			mk(-8388608,0,0, 8388607,0,0, 0,-1,-1, 8388607,1,1, 0, 0, 0));
		table_rows.insert(table_rows.size(),
			mk(8388607,5,5, -8388608,5,5, -100,0,0, 100,10,10, 0, 0, 0));
		table_rows.insert(table_rows.size(),
			mk(0,-300,0, 0,300,0, -1,-100,-1, 1,100,1, 0, 0, 0));
		table_rows.insert(table_rows.size(),
			mk(0,0,300, 0,0,-300, -1,-1,-100, 1,1,100, 0, 0, 0));
		table_rows.insert(table_rows.size(),
			mk(0,0,0, 256,0,0, 512,0,0, 0,0,0, 0, 0, 0));
		table_rows.insert(table_rows.size(),
			mk(0,0,0, 300,300,0, 100,200,-1, 400,500,1, 0, 0, 0));
		table_rows.insert(table_rows.size(),
			mk(0,0,0, 300,300,0, 200,100,-1, 250,150,1, 0, 0, 0));
		table_rows.insert(table_rows.size(),
			mk(-1,-1,-1, -1,-1,-1, -1,-1,-1, -1,-1,-1, 0, 0, 0));
		table_rows.insert(table_rows.size(),
			mk(3,7,11, 900,-800,700, 1,-500,-20, 600,400,300, 0, 0, 0));
		foreach (table_rows[i])
			send_item(table_rows[i]);

		// random phases under different idling
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 15 : 45) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 15 : 45) : 0;
			if (ph == 2)
				hold_req++;
			for (int i = 0; i < 145; i++)
				send_item(rnd_item());
			// sender pauses until all results are back
			if (ph == 1) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				waited = 0;
				while (expected_q.size() != 0 && waited < 100000) begin
					@(posedge clk);
					waited++;
				end
			end
		end
		s_tvalid <= 1'b0;

		waited = 0;
		while (expected_q.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("tb_segment_box_intersect: done, clean");
		else
			$display("tb_segment_box_intersect: done, errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/sbi_pkg.sv
hw/rtl/sbi_div.sv
hw/rtl/segment_box_intersect.sv
test/tb_segment_box_intersect.sv
